>>> hdl/scrf_pkg.sv
package scrf_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = 6;
    localparam int CW    = 7;

    localparam logic       REG_SIGMA  = 1'b0;
    localparam logic       REG_VCOUNT = 1'b1;
    localparam logic [15:0] SIGMA_RST  = 16'd768;
    localparam logic [3:0]  VCOUNT_RST = 4'd1;

    localparam logic [47:0] RATIO_POS_LIM = 48'h00_7F_FFFF_FFFF;
    localparam logic [47:0] RATIO_NEG_LIM = 48'h00_80_0000_0000;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               last;
    } in_t;

    typedef struct packed {
        logic signed [31:0] kept_x;
        logic signed [31:0] kept_y;
        logic               has_point;
        logic               final_res;
        logic [6:0]         removed_count;
        logic               error;
    } out_t;

    typedef struct packed {
        logic capture;
        logic store_xy;
        logic store_ratio;
        logic count_zero;
        logic div_ratio;
        logic div_mean;
        logic div_var;
        logic take_mean;
        logic idx_clr;
        logic idx_inc;
        logic dev_abs;
        logic dev_m0;
        logic dev_m1;
        logic dev_m2;
        logic dev_sq;
        logic dev_acc;
        logic take_var;
        logic take_thr;
        logic take_bnd;
        logic em_chk;
        logic em_put;
        logic out_err;
        logic out_fin;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic full;
        logic y_zero;
        logic n_lt2;
        logic multi_var;
        logic div_done;
        logic sqrt_done;
        logic idx_end;
        logic keep;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

>>> hdl/scrf_ram.sv
module scrf_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/scrf_div.sv
module scrf_div import scrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    input  logic [6:0]  iters,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    assign shifted = {rem_reg, q_reg[63]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[62:0], ge};
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider restarted while busy");
    a_done_clears_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider busy after finishing");

endmodule

>>> hdl/scrf_dp.sv
module scrf_dp import scrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  in_t         s_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  cmd_t        cmd,
    output status_t     sts,
    input  logic        m_ready,
    output logic        m_valid,
    output out_t        m_data
);

    in_t                in_reg;
    logic [6:0]         count_reg;
    logic [6:0]         idx_reg;
    logic [6:0]         kept_reg;
    logic signed [47:0] sum_reg;
    logic [63:0]        dev_reg;
    logic signed [47:0] mean_reg;
    logic [40:0]        a_reg;
    logic               ovf_reg;
    logic               ynz_reg;
    logic [41:0]        prod_reg;
    logic [66:0]        acc_reg;
    logic [47:0]        thr_reg;
    logic signed [49:0] upper_reg;
    logic signed [49:0] lower_reg;
    logic [31:0]        cand_x_reg;
    logic [31:0]        cand_y_reg;
    logic               keep_reg;
    logic               pend_valid_reg;
    logic [31:0]        pend_x_reg;
    logic [31:0]        pend_y_reg;
    logic               out_valid_reg;
    out_t               out_reg;
    logic [15:0]        sigma_reg;
    logic [3:0]         vc_reg;
    logic [63:0]        sq_v_reg;
    logic [34:0]        sq_rem_reg;
    logic [31:0]        sq_root_reg;
    logic [5:0]         sq_cnt_reg;
    logic               sq_busy_reg;
    logic               sq_done_reg;

    logic [31:0] x_rd;
    logic [31:0] y_rd;
    logic [39:0] r_rd;
    logic [31:0] abs_x;
    logic [31:0] abs_y;
    logic [47:0] abs_sum;
    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic [6:0]  div_iters;
    logic        div_done;
    logic [63:0] div_q;
    logic [47:0] qmag;
    logic        qneg;
    logic [39:0] ratio_sat;
    logic [48:0] dev_d;
    logic [48:0] dev_a;
    logic [20:0] mul_a;
    logic [20:0] mul_b;
    logic [63:0] sq_val;
    logic [64:0] dev_sum;
    logic [34:0] sq_rem_n;
    logic [34:0] sq_trial;
    logic signed [49:0] r_ext;
    logic signed [49:0] mean_ext;
    logic        out_free;
    logic        out_load;
    out_t        out_next;

    scrf_ram #(.WIDTH(32), .WORDS(DEPTH)) u_x_ram (
        .aclk(aclk), .we(cmd.store_xy), .waddr(count_reg[AW-1:0]),
        .wdata(in_reg.x_value), .raddr(idx_reg[AW-1:0]), .rdata(x_rd)
    );
    scrf_ram #(.WIDTH(32), .WORDS(DEPTH)) u_y_ram (
        .aclk(aclk), .we(cmd.store_xy), .waddr(count_reg[AW-1:0]),
        .wdata(in_reg.y_value), .raddr(idx_reg[AW-1:0]), .rdata(y_rd)
    );
    scrf_ram #(.WIDTH(40), .WORDS(DEPTH)) u_r_ram (
        .aclk(aclk), .we(cmd.store_ratio | cmd.count_zero), .waddr(count_reg[AW-1:0]),
        .wdata(cmd.store_ratio ? ratio_sat : 40'd0), .raddr(idx_reg[AW-1:0]),
        .rdata(r_rd)
    );

    assign abs_x   = in_reg.x_value[31] ? 32'(-in_reg.x_value) : in_reg.x_value;
    assign abs_y   = in_reg.y_value[31] ? 32'(-in_reg.y_value) : in_reg.y_value;
    assign abs_sum = sum_reg[47] ? 48'(-sum_reg) : sum_reg;

    assign div_start = cmd.div_ratio | cmd.div_mean | cmd.div_var;

    always_comb begin
        if (cmd.div_ratio) begin
            div_dividend = {abs_x, 32'd0};
            div_divisor  = abs_y;
            div_iters    = 7'd48;
        end else if (cmd.div_mean) begin
            div_dividend = {abs_sum, 16'd0};
            div_divisor  = {25'd0, count_reg};
            div_iters    = 7'd48;
        end else begin
            div_dividend = dev_reg;
            div_divisor  = {25'd0, 7'(count_reg - 7'd1)};
            div_iters    = 7'd64;
        end
    end

    scrf_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .iters(div_iters), .done(div_done), .quotient(div_q)
    );

    assign qmag = div_q[47:0];
    assign qneg = in_reg.x_value[31] ^ in_reg.y_value[31];

    always_comb begin
        if (qneg) begin
            ratio_sat = (qmag > RATIO_NEG_LIM) ? RATIO_NEG_LIM[39:0] : 40'(-qmag);
        end else begin
            ratio_sat = (qmag > RATIO_POS_LIM) ? RATIO_POS_LIM[39:0] : qmag[39:0];
        end
    end

    assign dev_d = {{9{r_rd[39]}}, r_rd} - {mean_reg[47], mean_reg};
    assign dev_a = dev_d[48] ? 49'(-dev_d) : dev_d;

    always_comb begin
        if (cmd.dev_m0) begin
            mul_a = {1'b0, a_reg[19:0]};
            mul_b = {1'b0, a_reg[19:0]};
        end else if (cmd.dev_m1) begin
            mul_a = a_reg[40:20];
            mul_b = {1'b0, a_reg[19:0]};
        end else begin
            mul_a = a_reg[40:20];
            mul_b = a_reg[40:20];
        end
    end

    assign sq_val  = (ovf_reg || (|acc_reg[66:64])) ? '1 : acc_reg[63:0];
    assign dev_sum = {1'b0, dev_reg} + {1'b0, sq_val};

    assign sq_rem_n = {sq_rem_reg[32:0], sq_v_reg[63:62]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};

    assign r_ext    = {{10{r_rd[39]}}, r_rd};
    assign mean_ext = {{2{mean_reg[47]}}, mean_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg <= SIGMA_RST;
            vc_reg    <= VCOUNT_RST;
        end else if (cfg_we) begin
            if (cfg_index == REG_SIGMA) begin
                sigma_reg <= cfg_data;
            end else begin
                vc_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            sum_reg        <= '0;
            dev_reg        <= '0;
            kept_reg       <= '0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (cmd.store_ratio) begin
                sum_reg   <= sum_reg + {{8{ratio_sat[39]}}, ratio_sat};
                count_reg <= count_reg + 7'd1;
            end
            if (cmd.count_zero) begin
                count_reg <= count_reg + 7'd1;
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 7'd1;
            end
            if (cmd.dev_acc && ynz_reg) begin
                dev_reg <= dev_sum[64] ? '1 : dev_sum[63:0];
            end
            if (cmd.em_put && keep_reg) begin
                kept_reg       <= kept_reg + 7'd1;
                pend_valid_reg <= 1'b1;
            end
            if (cmd.clear) begin
                count_reg      <= '0;
                sum_reg        <= '0;
                dev_reg        <= '0;
                kept_reg       <= '0;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.take_mean) begin
            mean_reg <= sum_reg[47] ? 48'(-qmag) : qmag;
        end
        if (cmd.dev_abs) begin
            a_reg   <= dev_a[40:0];
            ovf_reg <= dev_a[40];
            ynz_reg <= y_rd != 32'd0;
        end
        if (cmd.dev_m0 || cmd.dev_m1 || cmd.dev_m2) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.dev_m1) begin
            acc_reg <= {41'd0, prod_reg[41:16]};
        end else if (cmd.dev_m2) begin
            acc_reg <= acc_reg + {20'd0, prod_reg, 5'd0};
        end else if (cmd.dev_sq) begin
            acc_reg <= acc_reg + {1'b0, prod_reg, 24'd0};
        end
        if (cmd.take_thr) begin
            thr_reg <= sigma_reg * sq_root_reg;
        end
        if (cmd.take_bnd) begin
            upper_reg <= mean_ext + $signed({2'b00, thr_reg});
            lower_reg <= mean_ext - $signed({2'b00, thr_reg});
        end
        if (cmd.em_chk) begin
            cand_x_reg <= x_rd;
            cand_y_reg <= y_rd;
            keep_reg   <= (y_rd != 32'd0) && (r_ext > lower_reg) && (r_ext < upper_reg);
        end
        if (cmd.em_put && keep_reg) begin
            pend_x_reg <= cand_x_reg;
            pend_y_reg <= cand_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end else begin
            sq_done_reg <= 1'b0;
            if (cmd.take_var) begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '1;
            end else if (sq_busy_reg) begin
                sq_cnt_reg <= sq_cnt_reg - 6'd1;
                if (sq_cnt_reg == 6'd32) begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_var) begin
            sq_v_reg    <= div_q;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end else if (sq_busy_reg) begin
            sq_v_reg <= {sq_v_reg[61:0], 2'b00};
            if (sq_rem_n >= sq_trial) begin
                sq_rem_reg  <= sq_rem_n - sq_trial;
                sq_root_reg <= {sq_root_reg[30:0], 1'b1};
            end else begin
                sq_rem_reg  <= sq_rem_n;
                sq_root_reg <= {sq_root_reg[30:0], 1'b0};
            end
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign out_load = cmd.out_err || cmd.out_fin || (cmd.em_put && keep_reg && pend_valid_reg);

    always_comb begin
        out_next = '0;
        if (cmd.out_err) begin
            out_next.error     = 1'b1;
            out_next.final_res = 1'b1;
        end else if (cmd.out_fin) begin
            out_next.kept_x        = pend_valid_reg ? pend_x_reg : 32'd0;
            out_next.kept_y        = pend_valid_reg ? pend_y_reg : 32'd0;
            out_next.has_point     = pend_valid_reg;
            out_next.final_res     = 1'b1;
            out_next.removed_count = count_reg - kept_reg;
        end else begin
            out_next.kept_x    = pend_x_reg;
            out_next.kept_y    = pend_y_reg;
            out_next.has_point = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign sts.last       = in_reg.last;
    assign sts.full       = count_reg == 7'(DEPTH);
    assign sts.y_zero     = in_reg.y_value == 32'sd0;
    assign sts.n_lt2      = count_reg < 7'd2;
    assign sts.multi_var  = vc_reg > 4'd1;
    assign sts.div_done   = div_done;
    assign sts.sqrt_done  = sq_done_reg;
    assign sts.idx_end    = idx_reg == 7'(count_reg - 7'd1);
    assign sts.keep       = keep_reg;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 7'(DEPTH))
        else $error("pair count beyond depth");
    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_reg <= count_reg)
        else $error("more pairs kept than loaded");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result overwritten before taken");
    a_store_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_xy |-> count_reg < 7'(DEPTH))
        else $error("store beyond depth");

endmodule

>>> hdl/scrf_ctrl.sv
module scrf_ctrl import scrf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    localparam logic [4:0] S_LOAD    = 5'd0;
    localparam logic [4:0] S_LD_CHK  = 5'd1;
    localparam logic [4:0] S_LD_DIV  = 5'd2;
    localparam logic [4:0] S_LD_DONE = 5'd3;
    localparam logic [4:0] S_ERR     = 5'd4;
    localparam logic [4:0] S_MEAN    = 5'd5;
    localparam logic [4:0] S_DEV_RD  = 5'd6;
    localparam logic [4:0] S_DEV_ABS = 5'd7;
    localparam logic [4:0] S_DEV_M0  = 5'd8;
    localparam logic [4:0] S_DEV_M1  = 5'd9;
    localparam logic [4:0] S_DEV_M2  = 5'd10;
    localparam logic [4:0] S_DEV_SQ  = 5'd11;
    localparam logic [4:0] S_DEV_ACC = 5'd12;
    localparam logic [4:0] S_VAR_GO  = 5'd13;
    localparam logic [4:0] S_VAR     = 5'd14;
    localparam logic [4:0] S_SQRT    = 5'd15;
    localparam logic [4:0] S_BND     = 5'd16;
    localparam logic [4:0] S_EM_RD   = 5'd17;
    localparam logic [4:0] S_EM_CHK  = 5'd18;
    localparam logic [4:0] S_EM_PUT  = 5'd19;
    localparam logic [4:0] S_EM_FIN  = 5'd20;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = aresetn && (state_reg == S_LOAD);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LD_CHK;
                end
            end
            S_LD_CHK: begin
                if (sts.full) begin
                    state_next = S_LD_DONE;
                end else begin
                    cmd.store_xy = 1'b1;
                    if (sts.y_zero) begin
                        cmd.count_zero = 1'b1;
                        state_next     = S_LD_DONE;
                    end else begin
                        cmd.div_ratio = 1'b1;
                        state_next    = S_LD_DIV;
                    end
                end
            end
            S_LD_DIV: begin
                if (sts.div_done) begin
                    cmd.store_ratio = 1'b1;
                    state_next      = S_LD_DONE;
                end
            end
            S_LD_DONE: begin
                if (!sts.last) begin
                    state_next = S_LOAD;
                end else if (sts.multi_var) begin
                    state_next = S_ERR;
                end else if (sts.n_lt2) begin
                    state_next = S_EM_FIN;
                end else begin
                    cmd.div_mean = 1'b1;
                    state_next   = S_MEAN;
                end
            end
            S_ERR: begin
                if (sts.out_free) begin
                    cmd.out_err = 1'b1;
                    cmd.clear   = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_MEAN: begin
                if (sts.div_done) begin
                    cmd.take_mean = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = S_DEV_RD;
                end
            end
            S_DEV_RD:  state_next = S_DEV_ABS;
            S_DEV_ABS: begin
                cmd.dev_abs = 1'b1;
                state_next  = S_DEV_M0;
            end
            S_DEV_M0: begin
                cmd.dev_m0 = 1'b1;
                state_next = S_DEV_M1;
            end
            S_DEV_M1: begin
                cmd.dev_m1 = 1'b1;
                state_next = S_DEV_M2;
            end
            S_DEV_M2: begin
                cmd.dev_m2 = 1'b1;
                state_next = S_DEV_SQ;
            end
            S_DEV_SQ: begin
                cmd.dev_sq = 1'b1;
                state_next = S_DEV_ACC;
            end
            S_DEV_ACC: begin
                cmd.dev_acc = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = sts.idx_end ? S_VAR_GO : S_DEV_RD;
            end
            S_VAR_GO: begin
                cmd.div_var = 1'b1;
                state_next  = S_VAR;
            end
            S_VAR: begin
                if (sts.div_done) begin
                    cmd.take_var = 1'b1;
                    state_next   = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sts.sqrt_done) begin
                    cmd.take_thr = 1'b1;
                    state_next   = S_BND;
                end
            end
            S_BND: begin
                cmd.take_bnd = 1'b1;
                cmd.idx_clr  = 1'b1;
                state_next   = S_EM_RD;
            end
            S_EM_RD:  state_next = S_EM_CHK;
            S_EM_CHK: begin
                cmd.em_chk = 1'b1;
                state_next = S_EM_PUT;
            end
            S_EM_PUT: begin
                if (!(sts.keep && sts.pend_valid && !sts.out_free)) begin
                    cmd.em_put  = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = sts.idx_end ? S_EM_FIN : S_EM_RD;
                end
            end
            S_EM_FIN: begin
                if (sts.out_free) begin
                    cmd.out_fin = 1'b1;
                    cmd.clear   = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    a_capture_only_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> state_reg == S_LOAD)
        else $error("request captured outside load");
    a_run_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> state_reg == S_LOAD)
        else $error("run cleared without returning to load");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_ratio || cmd.div_mean || cmd.div_var) |=> !sts.div_done)
        else $error("divider done too early");

endmodule

>>> hdl/sigma_clip_ratio_filter_top.sv
// Sigma-clipping ratio filter. Pairs (x, y) arrive one request at a time; each
// pair with nonzero y gets its ratio x/y in signed Q24.16 from a shared restoring
// divider run for 48 steps. The pair flagged last closes the run: the mean is
// divided out, squared deviations are accumulated pair by pair, the variance is
// divided out and its square root taken, then every pair is re-read and those with
// nonzero y strictly inside mean +/- sigma * stdev are sent out in load order, the
// last one flagged final with the removed count. Runs with fewer than two pairs
// give one empty final result; a variable count above one gives a single error
// result. Up to 64 pairs are held per run; further pairs are dropped.
module sigma_clip_ratio_filter_top import scrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t    cmd;
    status_t sts;

    scrf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    scrf_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
        .m_ready(m_ready), .m_valid(m_valid), .m_data(m_data)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import scrf_pkg::*;

    localparam int  LIMIT_CYCLES = 1500000;
    localparam int  SETTLE       = 1200;
    localparam int  NUM_RANDOM   = 420;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        bit          is_cfg;
        logic        cfg_idx;
        logic [15:0] cfg_val;
        in_t         item;
        bit          typed;
        out_t        res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    idle_mode_t  idle_mode;
    int          fail_count;
    int          cycle_count;
    out_t        kept_queue[$];

    logic [15:0]        sigma_q88;
    logic [3:0]         var_count;
    logic signed [31:0] x_mem[DEPTH];
    logic signed [31:0] y_mem[DEPTH];
    longint             ratio_mem[DEPTH];
    int                 held_pairs;
    longint             ratio_total;

    sigma_clip_ratio_filter_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_ready <= ($urandom_range(99) >= 75);
            IDLE_BOTH:     m_ready <= ($urandom_range(99) >= 7);
            default:       m_ready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (kept_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                fail_count++;
            end else begin
                want = kept_queue.pop_front();
                if (m_data.kept_x !== want.kept_x || m_data.kept_y !== want.kept_y ||
                    m_data.has_point !== want.has_point ||
                    m_data.final_res !== want.final_res ||
                    m_data.removed_count !== want.removed_count ||
                    m_data.error !== want.error) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, m_data);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic clear_run();
        held_pairs  = 0;
        ratio_total = 0;
    endtask

    task automatic filter_pair(input in_t it, output out_t res[$]);
        longint      q;
        longint      mean;
        longint      d;
        longint      upper;
        longint      lower;
        logic [63:0] mag;
        logic [127:0] sq;
        logic [63:0] dev_total;
        logic [63:0] thr;
        out_t        r;
        int          n;
        int          kept;
        res = {};
        if (held_pairs < DEPTH) begin
            x_mem[held_pairs] = it.x_value;
            y_mem[held_pairs] = it.y_value;
            if (it.y_value != 0) begin
                q = (longint'(it.x_value) * 65536) / longint'(it.y_value);
                if (q > 64'sd549755813887) q = 64'sd549755813887;
                if (q < -64'sd549755813888) q = -64'sd549755813888;
                ratio_mem[held_pairs] = q;
                ratio_total += q;
            end else begin
                ratio_mem[held_pairs] = 0;
            end
            held_pairs++;
        end
        if (!it.last) return;
        n = held_pairs;
        kept = 0;
        if (var_count > 1) begin
            r = '0;
            r.final_res = 1'b1;
            r.error = 1'b1;
            res.push_back(r);
            clear_run();
            return;
        end
        if (n >= 2) begin
            mean = ratio_total / longint'(n);
            dev_total = 0;
            for (int i = 0; i < n; i++) begin
                if (y_mem[i] != 0) begin
                    d = ratio_mem[i] - mean;
                    mag = (d < 0) ? -d : d;
                    sq = ({64'd0, mag} * {64'd0, mag}) >> 16;
                    dev_total = sat_sum(dev_total, (sq[127:64] != 0) ? '1 : sq[63:0]);
                end
            end
            thr = {48'd0, sigma_q88} * floor_sqrt(dev_total / (n - 1));
            upper = mean + longint'(thr);
            lower = mean - longint'(thr);
            for (int i = 0; i < n; i++) begin
                if (y_mem[i] != 0 && ratio_mem[i] < upper && ratio_mem[i] > lower) begin
                    r = '0;
                    r.kept_x = x_mem[i];
                    r.kept_y = y_mem[i];
                    r.has_point = 1'b1;
                    res.push_back(r);
                    kept++;
                end
            end
        end
        if (res.size() == 0) res.push_back(out_t'('0));
        res[res.size() - 1].final_res = 1'b1;
        res[res.size() - 1].removed_count = 7'(n - kept);
        clear_run();
    endtask

    task automatic send_request(input in_t it, input bit typed, input out_t typed_res);
        int   pct;
        out_t res[$];
        pct = (idle_mode == IDLE_SENDER) ? 75 : (idle_mode == IDLE_BOTH) ? 7 : 0;
        while ($urandom_range(99) < pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        filter_pair(it, res);
        if (typed && it.last) kept_queue.push_back(typed_res);
        else foreach (res[i]) kept_queue.push_back(res[i]);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (kept_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_SIGMA) sigma_q88 = val;
        else var_count = val[3:0];
    endtask

    function automatic stim_row_t pair_row(longint x, longint y, bit last);
        stim_row_t r;
        r = '{default: '0};
        r.item.x_value = 32'(x);
        r.item.y_value = 32'(y);
        r.item.last = last;
        return r;
    endfunction

    function automatic stim_row_t typed_row(longint x, longint y, logic [6:0] removed,
                                            bit err);
        stim_row_t r;
        r = pair_row(x, y, 1'b1);
        r.typed = 1'b1;
        r.res.final_res = 1'b1;
        r.res.removed_count = removed;
        r.res.error = err;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic idx, logic [15:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(200)) - 100);
            2:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom & 32'h0000_FFFF;
        endcase
    endfunction

    initial begin
        stim_row_t   rows[$];
        in_t         it;
        int          sent;
        int          run_len;
        int          base;
        logic [31:0] yv;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b1;
        cfg_we      = 1'b0;
        cfg_index   = REG_SIGMA;
        cfg_data    = '0;
        idle_mode   = IDLE_NONE;
        fail_count  = 0;
        cycle_count = 0;
        sigma_q88   = SIGMA_RST;
        var_count   = VCOUNT_RST;
        clear_run();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        rows.push_back(typed_row(5, 1, 7'd1, 1'b0));
        rows.push_back(typed_row(9, 0, 7'd1, 1'b0));
        rows.push_back(pair_row(100, 1, 0));
        rows.push_back(pair_row(101, 1, 0));
        rows.push_back(pair_row(99, 1, 0));
        rows.push_back(pair_row(10000, 1, 0));
        rows.push_back(pair_row(100, 1, 1));
        rows.push_back(pair_row(-2147483648, 1, 0));
        rows.push_back(pair_row(2147483647, 1, 0));
        rows.push_back(pair_row(-2147483648, -1, 0));
        rows.push_back(pair_row(2147483647, -1, 0));
        rows.push_back(pair_row(0, -2147483648, 0));
        rows.push_back(pair_row(-2147483648, 2147483647, 1));
        rows.push_back(pair_row(1, 0, 0));
        rows.push_back(typed_row(2, 0, 7'd2, 1'b0));
        rows.push_back(pair_row(7, 7, 0));
        rows.push_back(typed_row(7, 7, 7'd2, 1'b0));
        rows.push_back(cfg_row(REG_SIGMA, 16'd0));
        rows.push_back(pair_row(3, 1, 0));
        rows.push_back(pair_row(4, 1, 1));
        rows.push_back(cfg_row(REG_SIGMA, 16'hFFFF));
        rows.push_back(pair_row(3, 1, 0));
        rows.push_back(pair_row(4, 1, 0));
        rows.push_back(pair_row(-7, 2, 1));
        rows.push_back(cfg_row(REG_VCOUNT, 16'd15));
        rows.push_back(pair_row(6, 3, 0));
        rows.push_back(typed_row(1, 1, 7'd0, 1'b1));
        rows.push_back(cfg_row(REG_VCOUNT, 16'd2));
        rows.push_back(typed_row(1, 1, 7'd0, 1'b1));
        rows.push_back(cfg_row(REG_VCOUNT, 16'd1));
        rows.push_back(cfg_row(REG_SIGMA, SIGMA_RST));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            else send_request(rows[i].item, rows[i].typed, rows[i].res);
        end

        sent = 0;
        while (sent < NUM_RANDOM) begin
            if ($urandom_range(5) == 0) begin
                case ($urandom_range(5))
                    0: write_reg(REG_SIGMA, 16'd0);
                    1: write_reg(REG_SIGMA, 16'hFFFF);
                    2: write_reg(REG_SIGMA, 16'($urandom));
                    3: write_reg(REG_SIGMA, 16'($urandom_range(1024, 64)));
                    4: write_reg(REG_VCOUNT, 16'($urandom_range(15, 2)));
                    default: write_reg(REG_VCOUNT, 16'd1);
                endcase
            end
            if ($urandom_range(3) == 0) begin
                drain();
                idle_mode = idle_mode_t'($urandom_range(3));
            end
            run_len = ($urandom_range(30) == 0) ? $urandom_range(70, 64)
                                                : $urandom_range(8, 1);
            base = $signed($urandom_range(2000)) - 1000;
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(3) == 0) begin
                    it.x_value = rand_word();
                    it.y_value = ($urandom_range(5) == 0) ? 32'd0 : rand_word();
                end else begin
                    yv = 32'($urandom_range(300, 1));
                    if ($urandom_range(1)) yv = -yv;
                    it.y_value = ($urandom_range(15) == 0) ? 32'd0 : yv;
                    it.x_value = 32'($signed(yv) * base + $signed($urandom_range(40)) - 20);
                end
                it.last = (k == run_len - 1) || ($urandom_range(40) == 0);
                send_request(it, 1'b0, out_t'('0));
                sent++;
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
